### rtl/srd_pkg.sv
// Shared types, opcodes, status codes and split tables for the sprite
// run-length row decoder. No dependencies; used by every module under rtl.
`timescale 1ns / 1ps
`default_nettype none

package srd_pkg;

    // default frame dimension cap handed to the top level
    localparam int unsigned MAX_DIM_DEFAULT = 4096;
    // colour indices at or above this count are always refused
    localparam int unsigned MAX_PALETTE     = 256;

    // register widths
    localparam int unsigned DIM_REG_W   = 13;
    localparam int unsigned PAL_REG_W   = 9;
    localparam int unsigned SPLIT_REG_W = 4;
    localparam int unsigned CFG_DATA_W  = 13;
    localparam int unsigned CFG_IDX_W   = 2;
    // largest value a dimension register can hold
    localparam int unsigned DIM_REG_MAX = (1 << DIM_REG_W) - 1;

    // result field widths
    localparam int unsigned POS_W   = 12;
    localparam int unsigned LEN_W   = 9;
    localparam int unsigned COLOR_W = 8;

    // result queue
    localparam int unsigned QUEUE_DEPTH = 4;

    // register indices
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH     = 2'd0,
        CFG_FRAME_HEIGHT    = 2'd1,
        CFG_PALETTE_ENTRIES = 2'd2,
        CFG_SPLIT_MODE      = 2'd3
    } srd_cfg_idx_t;

    // stream opcodes
    localparam logic [7:0] OP_END_FRAME  = 8'hff;
    localparam logic [7:0] OP_END_ROW    = 8'hfe;
    localparam logic [7:0] OP_FILL       = 8'hfd;
    localparam logic [7:0] OP_SKIP       = 8'hfc;
    localparam logic [7:0] OP_COLOR_BASE = 8'hfb;

    // result kinds
    typedef enum logic [2:0] {
        ST_RUN          = 3'd0,
        ST_COMPLETE     = 3'd1,
        ST_TRUNCATED    = 3'd2,
        ST_ROW_OVERFLOW = 3'd3,
        ST_BAD_COLOR    = 3'd4
    } srd_status_t;

    // configuration as seen by the decoder
    typedef struct packed {
        logic [DIM_REG_W-1:0]   frame_width;
        logic [DIM_REG_W-1:0]   frame_height;
        logic [PAL_REG_W-1:0]   palette_entries;
        logic [SPLIT_REG_W-1:0] split_mode;
    } srd_cfg_t;

    // one result item
    typedef struct packed {
        srd_status_t        status;
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   column;
        logic [LEN_W-1:0]   run_length;
        logic [COLOR_W-1:0] color_index;
        logic               opaque;
        logic               last_of_item;
    } srd_result_t;

    // up to two results written into the queue in one cycle
    typedef struct packed {
        logic [1:0]  count;
        srd_result_t first;
        srd_result_t second;
    } srd_push_t;

    // length mask of a short run opcode
    function automatic logic [7:0] run_mask(input logic [SPLIT_REG_W-1:0] split);
        logic [7:0] m;
        case (split)
            4'd0:    m = 8'h00;
            4'd1:    m = 8'h01;
            4'd2:    m = 8'h03;
            4'd3:    m = 8'h07;
            4'd4:    m = 8'h0f;
            4'd5:    m = 8'h1f;
            4'd6:    m = 8'h3f;
            4'd7:    m = 8'h7f;
            4'd8:    m = 8'hff;
            4'd9:    m = 8'h00;
            4'd10:   m = 8'h01;
            4'd11:   m = 8'h02;
            4'd12:   m = 8'h03;
            4'd13:   m = 8'h04;
            4'd14:   m = 8'h05;
            default: m = 8'h06;
        endcase
        return m;
    endfunction

    // colour shift of a short run opcode
    function automatic logic [3:0] run_shift(input logic [SPLIT_REG_W-1:0] split);
        logic [3:0] s;
        case (split)
            4'd0:    s = 4'd0;
            4'd1:    s = 4'd1;
            4'd2:    s = 4'd2;
            4'd3:    s = 4'd3;
            4'd4:    s = 4'd4;
            4'd5:    s = 4'd5;
            4'd6:    s = 4'd6;
            4'd7:    s = 4'd7;
            4'd8:    s = 4'd8;
            4'd9:    s = 4'd0;
            4'd10:   s = 4'd1;
            4'd11:   s = 4'd2;
            4'd12:   s = 4'd3;
            4'd13:   s = 4'd4;
            4'd14:   s = 4'd5;
            default: s = 4'd6;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

### rtl/srd_cfg_regs.sv
// Configuration registers of the sprite run-length decoder.
// Depends on srd_pkg for register indices, widths and the config struct.
`timescale 1ns / 1ps
`default_nettype none

module srd_cfg_regs
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [srd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [srd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output srd_pkg::srd_cfg_t                     cfg
);

    srd_pkg::srd_cfg_t cfg_reg;

    // register writes, no read-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width     <= srd_pkg::DIM_REG_W'(1);
            cfg_reg.frame_height    <= srd_pkg::DIM_REG_W'(1);
            cfg_reg.palette_entries <= srd_pkg::PAL_REG_W'(srd_pkg::MAX_PALETTE);
            cfg_reg.split_mode      <= '0;
        end
        else if (cfg_we)
        begin
            case (srd_pkg::srd_cfg_idx_t'(cfg_index))
                srd_pkg::CFG_FRAME_WIDTH:
                    cfg_reg.frame_width <= cfg_data[srd_pkg::DIM_REG_W-1:0];
                srd_pkg::CFG_FRAME_HEIGHT:
                    cfg_reg.frame_height <= cfg_data[srd_pkg::DIM_REG_W-1:0];
                srd_pkg::CFG_PALETTE_ENTRIES:
                    cfg_reg.palette_entries <= cfg_data[srd_pkg::PAL_REG_W-1:0];
                srd_pkg::CFG_SPLIT_MODE:
                    cfg_reg.split_mode <= cfg_data[srd_pkg::SPLIT_REG_W-1:0];
                default:
                    cfg_reg.split_mode <= cfg_reg.split_mode;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/srd_decoder.sv
// Input register and single-pass opcode decoder with frame state.
// Depends on srd_pkg; produces up to two results per byte for srd_out_queue.
`timescale 1ns / 1ps
`default_nettype none

module srd_decoder
#(
    parameter int unsigned MAX_DIM = srd_pkg::MAX_DIM_DEFAULT
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire srd_pkg::srd_cfg_t cfg,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [7:0]   in_byte,
    input  wire logic         in_last,
    input  wire logic         room,
    output srd_pkg::srd_push_t push
);

    // counters only ever reach the effective dimension
    localparam int unsigned DIM_LIMIT = (MAX_DIM < srd_pkg::DIM_REG_MAX) ?
                                        MAX_DIM : srd_pkg::DIM_REG_MAX;
    localparam int unsigned CNT_W = $clog2(DIM_LIMIT + 1);
    localparam int unsigned SUM_W = ((CNT_W > srd_pkg::LEN_W) ? CNT_W : srd_pkg::LEN_W) + 1;

    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_BASE_LO,
        PH_BASE_HI,
        PH_SKIP_LEN,
        PH_FILL_LEN,
        PH_FILL_COLOR
    } phase_t;

    phase_t             phase_reg,    phase_next;
    logic [7:0]         base_reg,     base_next;
    logic [7:0]         pending_reg,  pending_next;
    logic [CNT_W-1:0]   row_reg,      row_next;
    logic [CNT_W-1:0]   col_reg,      col_next;
    logic               finished_reg, finished_next;
    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               in_last_reg;

    logic               advance;
    logic [CNT_W-1:0]   w_eff;
    logic [CNT_W-1:0]   h_eff;
    logic [srd_pkg::PAL_REG_W-1:0] pal_eff;
    logic [7:0]         sr_mask;
    logic [3:0]         sr_shift;
    logic               is_short_run;

    logic                          run_go;
    logic [srd_pkg::LEN_W-1:0]     run_count;
    logic [srd_pkg::COLOR_W-1:0]   run_color;
    logic                          run_opq;
    logic [SUM_W-1:0]              run_sum;
    logic                          run_exceed;
    logic                          run_bad;
    srd_pkg::srd_result_t          run_res;
    srd_pkg::srd_result_t          done_res;
    srd_pkg::srd_result_t          trunc_res;
    srd_pkg::srd_result_t          prim_res;
    logic                          prim_valid;
    logic                          trunc_valid;

    // input register: a byte moves on when the queue has room for two results
    assign advance  = in_valid_reg && room;
    assign in_ready = !in_valid_reg || room;

    // effective limits
    assign w_eff = (cfg.frame_width > srd_pkg::DIM_REG_W'(DIM_LIMIT)) ?
                   CNT_W'(DIM_LIMIT) : CNT_W'(cfg.frame_width);
    assign h_eff = (cfg.frame_height > srd_pkg::DIM_REG_W'(DIM_LIMIT)) ?
                   CNT_W'(DIM_LIMIT) : CNT_W'(cfg.frame_height);
    assign pal_eff = (cfg.palette_entries > srd_pkg::PAL_REG_W'(srd_pkg::MAX_PALETTE)) ?
                     srd_pkg::PAL_REG_W'(srd_pkg::MAX_PALETTE) : cfg.palette_entries;

    assign sr_mask  = srd_pkg::run_mask(cfg.split_mode);
    assign sr_shift = srd_pkg::run_shift(cfg.split_mode);
    assign is_short_run = !(in_byte_reg inside {srd_pkg::OP_END_FRAME, srd_pkg::OP_END_ROW,
                                                 srd_pkg::OP_FILL, srd_pkg::OP_SKIP,
                                                 srd_pkg::OP_COLOR_BASE});

    // run operands for the current phase
    always_comb
    begin
        run_go    = 1'b0;
        run_count = '0;
        run_color = '0;
        run_opq   = 1'b0;
        case (phase_reg)
            PH_SKIP_LEN:
            begin
                run_go    = 1'b1;
                run_count = srd_pkg::LEN_W'(in_byte_reg) + srd_pkg::LEN_W'(1);
            end
            PH_FILL_COLOR:
            begin
                run_go    = 1'b1;
                run_count = srd_pkg::LEN_W'(pending_reg) + srd_pkg::LEN_W'(1);
                run_color = in_byte_reg;
                run_opq   = 1'b1;
            end
            PH_BASE_LO, PH_BASE_HI, PH_FILL_LEN:
            begin
                run_go = 1'b0;
            end
            // expecting opcode, unused codes included
            default:
            begin
                run_go    = is_short_run;
                run_count = srd_pkg::LEN_W'(in_byte_reg & sr_mask) + srd_pkg::LEN_W'(1);
                run_color = base_reg + (in_byte_reg >> sr_shift);
                run_opq   = 1'b1;
            end
        endcase
    end

    // run check against row end and palette
    assign run_sum    = SUM_W'(col_reg) + SUM_W'(run_count);
    assign run_exceed = run_sum > SUM_W'(w_eff);
    assign run_bad    = run_opq && ({1'b0, run_color} >= pal_eff);

    always_comb
    begin
        run_res.status       = run_exceed ? srd_pkg::ST_ROW_OVERFLOW :
                               run_bad    ? srd_pkg::ST_BAD_COLOR : srd_pkg::ST_RUN;
        run_res.row          = srd_pkg::POS_W'(row_reg);
        run_res.column       = srd_pkg::POS_W'(col_reg);
        run_res.run_length   = run_count;
        run_res.color_index  = run_color;
        run_res.opaque       = run_opq;
        run_res.last_of_item = 1'b0;

        done_res        = '0;
        done_res.status = srd_pkg::ST_COMPLETE;
        trunc_res        = '0;
        trunc_res.status = srd_pkg::ST_TRUNCATED;
    end

    // frame state update for the byte in the input register
    always_comb
    begin
        phase_next    = phase_reg;
        base_next     = base_reg;
        pending_next  = pending_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        finished_next = finished_reg;
        prim_valid    = 1'b0;
        prim_res      = done_res;
        trunc_valid   = 1'b0;

        if (advance && !finished_reg)
        begin
            if (row_reg >= h_eff)
            begin
                prim_valid    = 1'b1;
                finished_next = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    PH_BASE_LO:
                    begin
                        base_next  = in_byte_reg;
                        phase_next = PH_BASE_HI;
                    end
                    PH_BASE_HI:
                    begin
                        phase_next = PH_OPCODE;
                    end
                    PH_FILL_LEN:
                    begin
                        pending_next = in_byte_reg;
                        phase_next   = PH_FILL_COLOR;
                    end
                    PH_SKIP_LEN, PH_FILL_COLOR:
                    begin
                        phase_next = PH_OPCODE;
                    end
                    default:
                    begin
                        phase_next = PH_OPCODE;
                        case (in_byte_reg)
                            srd_pkg::OP_END_FRAME:
                            begin
                                prim_valid    = 1'b1;
                                finished_next = 1'b1;
                            end
                            srd_pkg::OP_END_ROW:
                            begin
                                row_next  = row_reg + CNT_W'(1);
                                col_next  = '0;
                                base_next = '0;
                                if ((row_reg + CNT_W'(1)) >= h_eff)
                                begin
                                    prim_valid    = 1'b1;
                                    finished_next = 1'b1;
                                end
                            end
                            srd_pkg::OP_COLOR_BASE: phase_next = PH_BASE_LO;
                            srd_pkg::OP_SKIP:       phase_next = PH_SKIP_LEN;
                            srd_pkg::OP_FILL:       phase_next = PH_FILL_LEN;
                            default:                phase_next = PH_OPCODE;
                        endcase
                    end
                endcase

                // one run per byte at most
                if (run_go)
                begin
                    prim_valid = 1'b1;
                    prim_res   = run_res;
                    if (run_exceed || run_bad)
                        finished_next = 1'b1;
                    else
                        col_next = CNT_W'(run_sum);
                end
            end

            // stream ends before the frame does
            if (in_last_reg && !finished_next)
            begin
                trunc_valid   = 1'b1;
                finished_next = 1'b1;
            end
        end

        // end of data rearms for the next frame
        if (advance && in_last_reg)
        begin
            phase_next    = PH_OPCODE;
            base_next     = '0;
            pending_next  = '0;
            row_next      = '0;
            col_next      = '0;
            finished_next = 1'b0;
        end
    end

    // results handed to the queue, last one flagged
    always_comb
    begin
        push = '0;
        if (prim_valid && trunc_valid)
        begin
            push.count                = 2'd2;
            push.first                = prim_res;
            push.second               = trunc_res;
            push.second.last_of_item  = 1'b1;
        end
        else if (prim_valid)
        begin
            push.count              = 2'd1;
            push.first              = prim_res;
            push.first.last_of_item = 1'b1;
        end
        else if (trunc_valid)
        begin
            push.count              = 2'd1;
            push.first              = trunc_res;
            push.first.last_of_item = 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_OPCODE;
            base_reg     <= '0;
            pending_reg  <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            finished_reg <= 1'b0;
            in_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            base_reg     <= base_next;
            pending_reg  <= pending_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            finished_reg <= finished_next;
            if (in_ready)
                in_valid_reg <= in_valid;
        end
    end

    // input payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= in_byte;
            in_last_reg <= in_last;
        end
    end

endmodule

`default_nettype wire

### rtl/srd_out_queue.sv
// Result queue: takes up to two results a cycle, gives one a cycle while out_ready is high.
// Depends on srd_pkg for the result and push structs.
`timescale 1ns / 1ps
`default_nettype none

module srd_out_queue
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire srd_pkg::srd_push_t push,
    output logic                  room,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output srd_pkg::srd_result_t  out_res
);

    localparam int unsigned PTR_W = $clog2(srd_pkg::QUEUE_DEPTH);
    localparam int unsigned CNT_W = PTR_W + 1;

    srd_pkg::srd_result_t mem [srd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = count_reg != '0;
    assign out_res   = mem[head_reg];
    // two free slots so a whole byte's results always fit
    assign room      = count_reg <= CNT_W'(srd_pkg::QUEUE_DEPTH - 2);

    // pointer and fill arithmetic
    always_comb
    begin
        head_next  = pop ? head_reg + PTR_W'(1) : head_reg;
        tail_next  = tail_reg + PTR_W'(push.count);
        count_next = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // result storage
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[tail_reg] <= push.first;
        if (push.count == 2'd2)
            mem[tail_reg + PTR_W'(1)] <= push.second;
    end

endmodule

`default_nettype wire

### rtl/sprite_rle_row_decoder_core.sv
// Top level of the sprite run-length row decoder.
// Depends on srd_pkg, srd_cfg_regs, srd_decoder and srd_out_queue.
//
//  channel  | direction | payload                                  | handshake
//  ---------+-----------+------------------------------------------+------------------
//  s_axis   | in        | tdata: data_byte; tlast: end_of_data     | s_tvalid/s_tready
//  m_axis   | out       | tdata: run fields; tuser: status;        | m_tvalid/m_tready
//           |           | tlast: last_of_item                      |
//  cfg      | in        | cfg_index selects register, cfg_data     | cfg_we, no wait
//
// One stream byte is taken every cycle while s_tready is high; its results pass
// through the input register, then the result queue. A byte giving two results
// holds the output for two transfers, one result per transfer.
// The four-entry result queue absorbs stalls on m_tready; s_tready falls when
// the input register holds a byte and fewer than two entries are free.
// rst_n clears frame state and the queue and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none

module sprite_rle_row_decoder_core
#(
    parameter int unsigned MAX_DIM = srd_pkg::MAX_DIM_DEFAULT
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // stream in
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,   // [7:0] data_byte
    input  wire logic                            s_tlast,   // end_of_data
    // results out
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [47:0]                          m_tdata,   // [11:0] row, [23:12] column,
                                                            // [32:24] run_length,
                                                            // [40:33] color_index,
                                                            // [41] opaque, rest zero
    output logic [2:0]                           m_tuser,   // [2:0] status
    output logic                                 m_tlast,   // last_of_item
    // configuration
    input  wire logic                            cfg_we,
    input  wire logic [srd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [srd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    srd_pkg::srd_cfg_t    cfg;
    srd_pkg::srd_push_t   push;
    srd_pkg::srd_result_t out_res;
    logic                 room;

    // register file
    srd_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // byte decode
    srd_decoder #(
        .MAX_DIM (MAX_DIM)
    ) u_decoder
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .room     (room),
        .push     (push)
    );

    // result queue
    srd_out_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // output packing
    assign m_tdata = {6'b0, out_res.opaque, out_res.color_index, out_res.run_length,
                      out_res.column, out_res.row};
    assign m_tuser = out_res.status;
    assign m_tlast = out_res.last_of_item;

endmodule

`default_nettype wire
